/* rtl/core/hdip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdip_pkg
// Shared types and constants for the HID report descriptor item parser.
// ----------------------------------------------------------------------------
package hdip_pkg;

   // data bytes kept per item; longer long-item data is counted, not stored
   localparam int VALUE_BYTES = 8;
   localparam int ACC_W       = 8 * VALUE_BYTES;
   localparam int IDX_W       = $clog2(VALUE_BYTES);

   localparam logic [3:0] LONG_TAG_NIBBLE = 4'hF;
   localparam logic [7:0] SIGNED_TAG_LOW  = 8'd1;   // logical minimum
   localparam logic [7:0] SIGNED_TAG_HIGH = 8'd5;   // unit exponent

   localparam logic [1:0] KIND_MAIN     = 2'd0;
   localparam logic [1:0] KIND_GLOBAL   = 2'd1;
   localparam logic [1:0] KIND_LOCAL    = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam int RSP_DATA_W = 152;
   localparam int RSP_USER_W = 4;

   // header and data of one finished item, before decoding
   typedef struct packed {
      logic [7:0]       prefix;
      logic [7:0]       long_tag;
      logic [7:0]       size;
      logic [ACC_W-1:0] accum;
      logic             cut;
   } hdip_raw_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [7:0]  item_tag;
      logic [7:0]  payload_length;
      logic        is_long_item;
      logic [63:0] value_zero_ext;
      logic [63:0] value_sign_ext;
      logic        reads_as_signed;
      logic        size_error;
      logic        truncated;
   } hdip_item_type;

   function automatic logic [7:0] short_size(input logic [1:0] code);
      logic [7:0] size;
      case (code)
         2'd0:    size = 8'd0;
         2'd1:    size = 8'd1;
         2'd2:    size = 8'd2;
         default: size = 8'd4;
      endcase
      return size;
   endfunction

   function automatic logic length_ok(input logic [7:0] len);
      return (len == 8'd0) || (len == 8'd1) || (len == 8'd2) || (len == 8'd4)
         || ((len == 8'd8) && (VALUE_BYTES >= 8));
   endfunction

endpackage

/* rtl/core/hdip_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdip_parse
// Byte-wise item framing: tracks header phase, gathers data bytes and
// flags the cycle on which an item completes or the descriptor ends.
// ----------------------------------------------------------------------------
module hdip_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            byte_in,
   input  logic                  final_in,
   output logic                  emit,
   output hdip_pkg::hdip_raw_type raw
);
   import hdip_pkg::*;

   localparam logic [1:0] PH_PREFIX = 2'd0;
   localparam logic [1:0] PH_LEN    = 2'd1;
   localparam logic [1:0] PH_TAG    = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       prefix_ff, prefix_in;
   logic [7:0]       tag_ff, tag_in;
   logic [7:0]       size_ff, size_in;
   logic [7:0]       bytes_ff, bytes_in;
   logic [ACC_W-1:0] accum_ff, accum_in;
   logic             done;

   always_comb begin
      phase_in  = phase_ff;
      prefix_in = prefix_ff;
      tag_in    = tag_ff;
      size_in   = size_ff;
      bytes_in  = bytes_ff;
      accum_in  = accum_ff;
      done      = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            size_in  = byte_in;
            phase_in = PH_TAG;
         end
         PH_TAG: begin
            tag_in = byte_in;
            if (size_ff == 8'd0) begin
               done = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (bytes_ff < 8'(VALUE_BYTES)) begin
               accum_in[{bytes_ff[IDX_W-1:0], 3'b000} +: 8] = byte_in;
            end
            bytes_in = bytes_ff + 8'd1;
            if (bytes_in >= size_ff) begin
               done = 1'b1;
            end
         end
         default: begin
            prefix_in = byte_in;
            tag_in    = 8'd0;
            bytes_in  = 8'd0;
            accum_in  = '0;
            if (byte_in[7:4] == LONG_TAG_NIBBLE) begin
               size_in  = 8'd0;
               phase_in = PH_LEN;
            end else begin
               size_in = short_size(byte_in[1:0]);
               if (size_in == 8'd0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
      endcase
      emit = done | final_in;
      if (emit) begin
         phase_in = PH_PREFIX;
      end
   end

   // item fields as they stand after this word
   assign raw.prefix   = prefix_in;
   assign raw.long_tag = tag_in;
   assign raw.size     = size_in;
   assign raw.accum    = accum_in;
   assign raw.cut      = ~done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         prefix_ff <= 8'd0;
         tag_ff    <= 8'd0;
         size_ff   <= 8'd0;
         bytes_ff  <= 8'd0;
         accum_ff  <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         tag_ff    <= tag_in;
         size_ff   <= size_in;
         bytes_ff  <= bytes_in;
         accum_ff  <= accum_in;
      end
   end

endmodule

/* rtl/core/hdip_format.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdip_format
// Decodes a finished item: kind, tag, size check and value extension.
// ----------------------------------------------------------------------------
module hdip_format (
   input  hdip_pkg::hdip_raw_type  raw,
   output hdip_pkg::hdip_item_type item
);
   import hdip_pkg::*;

   logic        is_long;
   logic [1:0]  kind;
   logic [7:0]  tag;
   logic        bad;
   logic [63:0] acc;
   logic [63:0] zv;
   logic [63:0] sv;

   assign is_long = (raw.prefix[7:4] == LONG_TAG_NIBBLE);
   assign kind    = is_long ? KIND_RESERVED : raw.prefix[3:2];
   assign tag     = is_long ? raw.long_tag : {4'd0, raw.prefix[7:4]};
   assign bad     = ~length_ok(raw.size);
   assign acc     = 64'(raw.accum);

   always_comb begin
      zv = '0;
      sv = '0;
      if (!bad) begin
         case (raw.size)
            8'd1: begin
               zv = {56'd0, acc[7:0]};
               sv = {{56{acc[7]}}, acc[7:0]};
            end
            8'd2: begin
               zv = {48'd0, acc[15:0]};
               sv = {{48{acc[15]}}, acc[15:0]};
            end
            8'd4: begin
               zv = {32'd0, acc[31:0]};
               sv = {{32{acc[31]}}, acc[31:0]};
            end
            8'd8: begin
               zv = acc;
               sv = acc;
            end
            default: begin
               zv = '0;
               sv = '0;
            end
         endcase
      end
   end

   assign item.item_kind       = kind;
   assign item.item_tag        = tag;
   assign item.payload_length  = raw.size;
   assign item.is_long_item    = is_long;
   assign item.value_zero_ext  = zv;
   assign item.value_sign_ext  = sv;
   assign item.reads_as_signed = ~is_long && (kind == KIND_GLOBAL)
                                 && (tag inside {[SIGNED_TAG_LOW:SIGNED_TAG_HIGH]});
   assign item.size_error      = bad;
   assign item.truncated       = raw.cut;

endmodule

/* rtl/core/hdip_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdip_out_buf
// Result register with a skid stage so the input side keeps running for
// one word after the receiver stalls.
// ----------------------------------------------------------------------------
module hdip_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  hdip_pkg::hdip_item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output hdip_pkg::hdip_item_type out_item,
   input  logic                    out_ready
);
   import hdip_pkg::*;

   logic          main_valid_ff;
   logic          skid_valid_ff;
   hdip_item_type main_ff;
   hdip_item_type skid_ff;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || out_ready) begin
         main_valid_ff <= skid_valid_ff | in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || out_ready) begin
         main_ff <= skid_valid_ff ? skid_ff : in_item;
      end else if (in_valid && !skid_valid_ff) begin
         skid_ff <= in_item;
      end
   end

endmodule

/* rtl/core/hid_descriptor_item_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_descriptor_item_parser
// Splits a HID report descriptor byte stream into decoded items.
// Input words: one descriptor byte in req_tdata, req_tlast on the last byte
// of the descriptor. One byte is taken per cycle while req_tready is high.
// Output words: one per finished item (or per item cut short by req_tlast),
// carrying tag, length, the data zero- and sign-extended, and status flags.
// The item goes to the result register when its last byte is taken, or to
// the skid stage behind a stalled result. Framing state updates in the same
// cycle the byte is taken, and the result register plus a one-word skid
// stage keep req_tready high through a single stalled result.
// If rsp_tready stays low, req_tready drops once the skid word is full and
// rises again in the cycle after the held result is taken.
// Reset (synchronous, active high) returns the parser to expecting a prefix
// byte and empties the result register and skid stage.
// ----------------------------------------------------------------------------
module hid_descriptor_item_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // descriptor_byte
   input  logic                              req_tlast,  // final_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] item_tag, [15:8] payload_length, [79:16] value_zero_ext,
   // [143:80] value_sign_ext, [144] size_error, [145] truncated, rest zero
   output logic [hdip_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] item_kind, [2] is_long_item, [3] reads_as_signed
   output logic [hdip_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import hdip_pkg::*;

   logic          take;
   logic          emit;
   hdip_raw_type  raw;
   hdip_item_type item;
   hdip_item_type rsp_item;

   assign take = req_tvalid & req_tready;

   hdip_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .byte_in  (req_tdata),
      .final_in (req_tlast),
      .emit     (emit),
      .raw      (raw)
   );

   hdip_format u_format (
      .raw  (raw),
      .item (item)
   );

   hdip_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take & emit),
      .in_item   (item),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_item  (rsp_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {6'd0,
                       rsp_item.truncated,
                       rsp_item.size_error,
                       rsp_item.value_sign_ext,
                       rsp_item.value_zero_ext,
                       rsp_item.payload_length,
                       rsp_item.item_tag};

   assign rsp_tuser = {rsp_item.reads_as_signed,
                       rsp_item.is_long_item,
                       rsp_item.item_kind};

endmodule
